### sv/egl_pkg.sv
// egl_pkg: shared types and constants of the gcd / lcm unit.
// Used by the channel interfaces, the controller, the datapath and the top level.
// No dependencies.
`default_nettype none

package egl_pkg;

    localparam int EGL_OPERAND_WIDTH = 32;   // default working width of the operands
    localparam int IN_OPND_W         = 32;   // operand field width on the request channel
    localparam int OPCODE_W          = 2;
    localparam int RESULT_W          = 64;

    localparam logic [OPCODE_W-1:0] OPC_GCD     = 2'd0;
    localparam logic [OPCODE_W-1:0] OPC_LCM     = 2'd1;
    localparam logic [OPCODE_W-1:0] OPC_COPRIME = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GCD,
        ST_DIV,
        ST_DONE
    } egl_state_t;

    // datapath operation for the current cycle
    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_LOAD,
        CMD_GCD_STEP,
        CMD_GCD_FINISH,
        CMD_DIV_STEP
    } egl_cmd_t;

    typedef struct packed {
        egl_cmd_t cmd;
        logic     in_ready;
        logic     out_load;
    } egl_ctrl_t;

    typedef struct packed {
        logic gcd_done;    // one of the Euclid operands has reached zero
        logic div_last;    // final quotient bit this cycle
        logic lcm_needed;  // lcm opcode with both operands non-zero
    } egl_status_t;

endpackage

`default_nettype wire

### sv/egl_if.sv
// egl_in_if / egl_out_if: valid/ready channels of the gcd / lcm unit.
// Depends on egl_pkg for the field widths.
`default_nettype none

interface egl_in_if;
    import egl_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [OPCODE_W-1:0]   opcode;
    logic [IN_OPND_W-1:0]  operand_a;
    logic [IN_OPND_W-1:0]  operand_b;

    modport source (output valid, output opcode, output operand_a, output operand_b,
                    input ready);
    modport sink   (input valid, input opcode, input operand_a, input operand_b,
                    output ready);
endinterface

interface egl_out_if;
    import egl_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [RESULT_W-1:0]  result;

    modport source (output valid, output result, input ready);
    modport sink   (input valid, input result, output ready);
endinterface

`default_nettype wire

### sv/euclid_gcd_lcm_unit.sv
// euclid_gcd_lcm_unit: top level of the gcd / lcm unit.
// Depends on egl_pkg, egl_if (egl_in_if, egl_out_if), egl_ctrl and egl_datapath.
`default_nettype none

// Takes one request transaction (opcode, operand_a, operand_b) at a time and
// returns one response transaction. Opcode 0 gives gcd(a, b), opcode 1 the exact
// 64-bit lcm, opcode 2 gives 1 when a and b are coprime and both non-zero,
// opcode 3 gives 0. A zero operand gives gcd = the other operand, lcm = 0.
// Only the low OPERAND_WIDTH bits of each operand are used. The gcd is found by
// the binary method on one shared subtractor: one shift, swap or subtract per
// cycle, the number of steps set by the operand values. For lcm the same
// subtractor then divides a by the gcd, one quotient bit a cycle, and the
// quotient times b is taken into the output register once that is free.
// The request side is not ready while an item is in work; a finished result
// sits in an output register, so the next request can be taken while the
// response still waits for its sink.

module euclid_gcd_lcm_unit #(
    parameter int OPERAND_WIDTH = egl_pkg::EGL_OPERAND_WIDTH
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    egl_in_if.sink     request,
    egl_out_if.source  response
);
    import egl_pkg::*;

    egl_ctrl_t             ctrl;
    egl_status_t           status;
    logic [RESULT_W-1:0]   dp_result;
    logic                  out_free;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [RESULT_W-1:0]   result_reg;

    // output stage is free when empty or being drained this cycle
    assign out_free = !out_valid_reg || response.ready;

    egl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (request.valid),
        .out_free (out_free),
        .status   (status),
        .ctrl     (ctrl)
    );

    egl_datapath #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .cmd       (ctrl.cmd),
        .opcode    (request.opcode),
        .operand_a (request.operand_a),
        .operand_b (request.operand_b),
        .status    (status),
        .result    (dp_result)
    );

    assign request.ready = ctrl.in_ready;

    always_comb
    begin
        priority if (ctrl.out_load)
            out_valid_next = 1'b1;
        else if (response.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // payload register, no reset needed
    always_ff @(posedge clk)
    begin
        if (ctrl.out_load)
            result_reg <= dp_result;
    end

    assign response.valid  = out_valid_reg;
    assign response.result = result_reg;

endmodule

`default_nettype wire

### sv/egl_ctrl.sv
// egl_ctrl: sequencer of the gcd / lcm unit; issues one datapath command a cycle.
// Depends on egl_pkg.
`default_nettype none

module egl_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic                 out_free,
    input  wire egl_pkg::egl_status_t status,
    output egl_pkg::egl_ctrl_t        ctrl
);
    import egl_pkg::*;

    egl_state_t state_reg;
    egl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_GCD;
            end
            ST_GCD:
            begin
                if (status.gcd_done)
                    state_next = status.lcm_needed ? ST_DIV : ST_DONE;
            end
            ST_DIV:
            begin
                if (status.div_last)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl.cmd      = CMD_HOLD;
        ctrl.in_ready = 1'b0;
        ctrl.out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                ctrl.in_ready = 1'b1;
                ctrl.cmd      = in_valid ? CMD_LOAD : CMD_HOLD;
            end
            ST_GCD:
            begin
                ctrl.cmd = status.gcd_done ? CMD_GCD_FINISH : CMD_GCD_STEP;
            end
            ST_DIV:
            begin
                ctrl.cmd = CMD_DIV_STEP;
            end
            ST_DONE:
            begin
                ctrl.out_load = out_free;
            end
            default:
            begin
                ctrl.cmd = CMD_HOLD;
            end
        endcase
    end

endmodule

`default_nettype wire

### sv/egl_datapath.sv
// egl_datapath: operand registers, shared subtractor, binary gcd steps,
// restoring division steps and the final result select. Depends on egl_pkg.
`default_nettype none

module egl_datapath #(
    parameter int OPERAND_WIDTH = egl_pkg::EGL_OPERAND_WIDTH
) (
    input  wire logic                                clk,
    input  wire egl_pkg::egl_cmd_t                   cmd,
    input  wire logic [egl_pkg::OPCODE_W-1:0]        opcode,
    input  wire logic [egl_pkg::IN_OPND_W-1:0]       operand_a,
    input  wire logic [egl_pkg::IN_OPND_W-1:0]       operand_b,
    output egl_pkg::egl_status_t                     status,
    output logic [egl_pkg::RESULT_W-1:0]             result
);
    import egl_pkg::*;

    localparam int W     = OPERAND_WIDTH;
    localparam int CNT_W = (W > 1) ? $clog2(W) : 1;

    logic [OPCODE_W-1:0] opcode_reg;
    logic [W-1:0]        a_reg;
    logic [W-1:0]        b_reg;
    logic [W-1:0]        x_reg;     // gcd operand, then dividend / quotient
    logic [W-1:0]        y_reg;     // gcd operand, then partial remainder
    logic [W-1:0]        g_reg;
    logic [CNT_W-1:0]    k_reg;     // common factors of two
    logic [CNT_W-1:0]    cnt_reg;

    logic [W:0]          sub_lhs;
    logic [W:0]          sub_rhs;
    logic [W:0]          diff;
    logic                borrow;
    logic                nonzero;
    logic [W-1:0]        g_base;
    logic [2*W-1:0]      product;

    // one shared subtractor: x - y for gcd, trial remainder - g for division
    always_comb
    begin
        if (cmd == CMD_DIV_STEP)
        begin
            sub_lhs = {y_reg, x_reg[W-1]};
            sub_rhs = {1'b0, g_reg};
        end
        else
        begin
            sub_lhs = {1'b0, x_reg};
            sub_rhs = {1'b0, y_reg};
        end
        diff   = sub_lhs - sub_rhs;
        borrow = diff[W];
    end

    assign nonzero = (a_reg != '0) && (b_reg != '0);
    assign g_base  = (x_reg == '0) ? y_reg : x_reg;

    always_ff @(posedge clk)
    begin
        unique case (cmd)
            CMD_LOAD:
            begin
                opcode_reg <= opcode;
                a_reg      <= operand_a[W-1:0];
                b_reg      <= operand_b[W-1:0];
                x_reg      <= operand_a[W-1:0];
                y_reg      <= operand_b[W-1:0];
                k_reg      <= '0;
            end
            CMD_GCD_STEP:
            begin
                priority if (!x_reg[0] && !y_reg[0])
                begin
                    x_reg <= x_reg >> 1;
                    y_reg <= y_reg >> 1;
                    k_reg <= k_reg + 1'b1;
                end
                else if (!x_reg[0])
                begin
                    x_reg <= x_reg >> 1;
                end
                else if (!y_reg[0])
                begin
                    y_reg <= y_reg >> 1;
                end
                else if (borrow)
                begin
                    x_reg <= y_reg;
                    y_reg <= x_reg;
                end
                else
                begin
                    x_reg <= diff[W-1:0];
                end
            end
            CMD_GCD_FINISH:
            begin
                g_reg   <= g_base << k_reg;
                x_reg   <= a_reg;
                y_reg   <= '0;
                cnt_reg <= '0;
            end
            CMD_DIV_STEP:
            begin
                if (borrow)
                    y_reg <= {y_reg[W-2:0], x_reg[W-1]};
                else
                    y_reg <= diff[W-1:0];
                x_reg   <= {x_reg[W-2:0], ~borrow};
                cnt_reg <= cnt_reg + 1'b1;
            end
            default:
            begin
                x_reg <= x_reg;
            end
        endcase
    end

    assign status.gcd_done   = (x_reg == '0) || (y_reg == '0);
    assign status.div_last   = (cnt_reg == CNT_W'(W - 1));
    assign status.lcm_needed = (opcode_reg == OPC_LCM) && nonzero;

    // quotient a / g times b; registered at the output stage
    assign product = {{W{1'b0}}, x_reg} * {{W{1'b0}}, b_reg};

    always_comb
    begin
        unique case (opcode_reg)
            OPC_GCD:     result = RESULT_W'(g_reg);
            OPC_LCM:     result = nonzero ? RESULT_W'(product) : '0;
            OPC_COPRIME: result = RESULT_W'(nonzero && (g_reg == W'(1)));
            default:     result = '0;
        endcase
    end

endmodule

`default_nettype wire
